// ===== rtl/spe_pkg.sv =====
package spe_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_TERMS_DEF    = 16;
    localparam int MAX_EXPONENT_DEF = 15;

    // Fixed field widths
    localparam int REQ_W     = 2;
    localparam int COEF_W    = 16;
    localparam int EXP_W     = 4;
    localparam int X_W       = 16;
    localparam int VAL_W     = 40;
    localparam int CNT_OUT_W = 5;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BACK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EVAL      = 2'd2;

    // Q32.8 saturation bounds
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // One stored term
    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic        [EXP_W-1:0]  expo;
    } term_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INSERT,
        ST_READ,
        ST_LOAD,
        ST_MUL,
        ST_ROUND,
        ST_ACC,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch_req;
        logic clear_eval;
        logic do_insert;
        logic mem_read;
        logic load_term;
        logic mul_step;
        logic round_step;
        logic acc_step;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req_code;
        logic             terms_left;
        logic             rd_exp_zero;
        logic             exp_last;
        logic             out_free;
    } stat_t;

endpackage

// ===== rtl/spe_ctrl.sv =====
module spe_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  spe_pkg::stat_t st,
    output spe_pkg::cmd_t  cmd
);

    spe_pkg::state_t state_reg;
    spe_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spe_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            spe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = spe_pkg::ST_DECODE;
                end
            end
            spe_pkg::ST_DECODE:
            begin
                cmd.clear_eval = 1'b1;
                unique case (st.req_code)
                    spe_pkg::REQ_INS_FRONT,
                    spe_pkg::REQ_INS_BACK: state_next = spe_pkg::ST_INSERT;
                    spe_pkg::REQ_EVAL:     state_next = spe_pkg::ST_READ;
                    default:               state_next = spe_pkg::ST_FINISH;
                endcase
            end
            spe_pkg::ST_INSERT:
            begin
                cmd.do_insert = 1'b1;
                state_next    = spe_pkg::ST_FINISH;
            end
            spe_pkg::ST_READ:
            begin
                if (st.terms_left)
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = spe_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = spe_pkg::ST_FINISH;
                end
            end
            spe_pkg::ST_LOAD:
            begin
                cmd.load_term = 1'b1;
                state_next    = st.rd_exp_zero ? spe_pkg::ST_ACC : spe_pkg::ST_MUL;
            end
            spe_pkg::ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = spe_pkg::ST_ROUND;
            end
            spe_pkg::ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                state_next     = st.exp_last ? spe_pkg::ST_ACC : spe_pkg::ST_MUL;
            end
            spe_pkg::ST_ACC:
            begin
                cmd.acc_step = 1'b1;
                state_next   = spe_pkg::ST_READ;
            end
            spe_pkg::ST_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = spe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/spe_dp.sv =====
module spe_dp #(
    parameter int MAX_TERMS    = spe_pkg::MAX_TERMS_DEF,
    parameter int MAX_EXPONENT = spe_pkg::MAX_EXPONENT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  spe_pkg::cmd_t                        cmd,
    output spe_pkg::stat_t                       st,
    input  logic [spe_pkg::REQ_W-1:0]            req_type,
    input  logic signed [spe_pkg::COEF_W-1:0]    coefficient,
    input  logic [spe_pkg::EXP_W-1:0]            exponent,
    input  logic signed [spe_pkg::X_W-1:0]       x_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [spe_pkg::VAL_W-1:0]     result_value,
    output logic                                 overflow,
    output logic                                 rejected,
    output logic [spe_pkg::CNT_OUT_W-1:0]        term_count
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam int VW    = spe_pkg::VAL_W;

    // Term store
    spe_pkg::term_t mem [MAX_TERMS];
    spe_pkg::term_t rd_data_reg;

    // Ring control
    logic [IDX_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] k_reg;

    // Latched request
    logic [spe_pkg::REQ_W-1:0]         req_reg;
    logic signed [spe_pkg::COEF_W-1:0] coef_reg;
    logic [spe_pkg::EXP_W-1:0]         exp_reg;
    logic signed [spe_pkg::X_W-1:0]    x_reg;

    // Evaluation datapath
    logic signed [VW-1:0]      p_reg;
    logic [spe_pkg::EXP_W-1:0] e_reg;
    logic signed [40:0]        plo_reg;
    logic signed [31:0]        phi_reg;
    logic                      neg_reg;
    logic signed [VW-1:0]      acc_reg;
    logic                      ovf_reg;
    logic                      rej_reg;

    // Output beat
    logic                               out_valid_reg;
    logic signed [VW-1:0]               val_out_reg;
    logic                               ovf_out_reg;
    logic                               rej_out_reg;
    logic [spe_pkg::CNT_OUT_W-1:0]      cnt_out_reg;

    logic                      full;
    logic [IDX_W-1:0]          front_pos;
    logic [SUM_W-1:0]          back_sum;
    logic [IDX_W-1:0]          back_pos;
    logic [IDX_W-1:0]          ins_pos;
    logic [spe_pkg::EXP_W-1:0] exp_clamped;
    logic [IDX_W-1:0]          rd_ptr_inc;
    logic signed [40:0]        plo_next;
    logic signed [31:0]        phi_next;
    logic signed [55:0]        rnd_sum;
    logic signed [47:0]        rnd_val;
    logic signed [VW-1:0]      rnd_sat;
    logic                      rnd_ovf;
    logic signed [VW:0]        acc_sum;
    logic signed [VW-1:0]      acc_sat;
    logic                      acc_ovf;

    // Insert position and clamped exponent
    always_comb
    begin
        full        = (count_reg == CNT_W'(MAX_TERMS));
        front_pos   = (head_reg == '0) ? IDX_W'(MAX_TERMS - 1) : head_reg - 1'b1;
        back_sum    = {1'b0, head_reg} + SUM_W'(count_reg);
        back_pos    = (back_sum >= SUM_W'(MAX_TERMS)) ?
                      IDX_W'(back_sum - SUM_W'(MAX_TERMS)) : back_sum[IDX_W-1:0];
        ins_pos     = (req_reg == spe_pkg::REQ_INS_FRONT) ? front_pos : back_pos;
        exp_clamped = (int'(exp_reg) > MAX_EXPONENT) ?
                      spe_pkg::EXP_W'(MAX_EXPONENT) : exp_reg;
        rd_ptr_inc  = (rd_ptr_reg == IDX_W'(MAX_TERMS - 1)) ? '0 : rd_ptr_reg + 1'b1;
    end

    // Split multiply: low 24 bits unsigned, high 16 bits signed
    always_comb
    begin
        plo_next = $signed({1'b0, p_reg[23:0]}) * x_reg;
        phi_next = $signed(p_reg[VW-1:24]) * x_reg;
    end

    // Recombine, round half away from zero, saturate
    always_comb
    begin
        rnd_sum = $signed({phi_reg, 24'b0}) + $signed({{15{plo_reg[40]}}, plo_reg})
                + (neg_reg ? 56'sd127 : 56'sd128);
        rnd_val = rnd_sum[55:8];
        rnd_ovf = 1'b1;
        if (rnd_val > 48'(spe_pkg::VAL_MAX))
        begin
            rnd_sat = spe_pkg::VAL_MAX;
        end
        else if (rnd_val < 48'(spe_pkg::VAL_MIN))
        begin
            rnd_sat = spe_pkg::VAL_MIN;
        end
        else
        begin
            rnd_sat = rnd_val[VW-1:0];
            rnd_ovf = 1'b0;
        end
    end

    // Running sum with saturation
    always_comb
    begin
        acc_sum = (VW+1)'(acc_reg) + (VW+1)'(p_reg);
        acc_ovf = 1'b1;
        if (acc_sum > (VW+1)'(spe_pkg::VAL_MAX))
        begin
            acc_sat = spe_pkg::VAL_MAX;
        end
        else if (acc_sum < (VW+1)'(spe_pkg::VAL_MIN))
        begin
            acc_sat = spe_pkg::VAL_MIN;
        end
        else
        begin
            acc_sat = acc_sum[VW-1:0];
            acc_ovf = 1'b0;
        end
    end

    // Term store write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.do_insert && !full)
        begin
            mem[ins_pos] <= '{coef: coef_reg, expo: exp_clamped};
        end
        if (cmd.mem_read)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // Control state: ring pointers and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_insert && !full)
            begin
                if (req_reg == spe_pkg::REQ_INS_FRONT)
                begin
                    head_reg <= front_pos;
                end
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_reg  <= req_type;
            coef_reg <= coefficient;
            exp_reg  <= exponent;
            x_reg    <= x_value;
        end
        if (cmd.clear_eval)
        begin
            acc_reg    <= '0;
            ovf_reg    <= 1'b0;
            rej_reg    <= 1'b0;
            rd_ptr_reg <= head_reg;
            k_reg      <= '0;
        end
        if (cmd.do_insert && full)
        begin
            rej_reg <= 1'b1;
        end
        if (cmd.load_term)
        begin
            p_reg <= $signed({{(VW-spe_pkg::COEF_W-8){rd_data_reg.coef[spe_pkg::COEF_W-1]}},
                              rd_data_reg.coef, 8'b0});
            e_reg <= rd_data_reg.expo;
        end
        if (cmd.mul_step)
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
            neg_reg <= p_reg[VW-1] ^ x_reg[spe_pkg::X_W-1];
        end
        if (cmd.round_step)
        begin
            p_reg <= rnd_sat;
            e_reg <= e_reg - 1'b1;
            if (rnd_ovf)
            begin
                ovf_reg <= 1'b1;
            end
        end
        if (cmd.acc_step)
        begin
            acc_reg    <= acc_sat;
            rd_ptr_reg <= rd_ptr_inc;
            k_reg      <= k_reg + 1'b1;
            if (acc_ovf)
            begin
                ovf_reg <= 1'b1;
            end
        end
        if (cmd.load_out)
        begin
            val_out_reg <= acc_reg;
            ovf_out_reg <= ovf_reg;
            rej_out_reg <= rej_reg;
            cnt_out_reg <= spe_pkg::CNT_OUT_W'(count_reg);
        end
    end

    // Status to controller
    always_comb
    begin
        st.req_code    = req_reg;
        st.terms_left  = (k_reg < count_reg);
        st.rd_exp_zero = (rd_data_reg.expo == '0);
        st.exp_last    = (e_reg == spe_pkg::EXP_W'(1));
        st.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = val_out_reg;
    assign overflow     = ovf_out_reg;
    assign rejected     = rej_out_reg;
    assign term_count   = cnt_out_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TERMS))
        else $error("term count above capacity");

    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_read |-> (rd_ptr_reg <= IDX_W'(MAX_TERMS - 1)) &&
                         (head_reg <= IDX_W'(MAX_TERMS - 1)))
        else $error("ring pointer out of range");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert && !full |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted insert did not grow the store");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out && rej_reg |-> full)
        else $error("reject flagged with room in the store");

endmodule

// ===== rtl/sparse_polynomial_evaluator_unit.sv =====
// Sparse polynomial evaluator: ring store of terms, evaluated one multiply at a time.
// Insert: the request passes the decode and insert states, and the finish state registers the result beat.
// Evaluate: each term is read and loaded, then each power step passes through the shared
// split multiplier and the round/saturate stage before the term is accumulated.
// One request at a time: a new beat is not taken until the last one has finished; the next beat
// is taken while a result waits. Reset (rst_n low, asynchronous) empties the store.
module sparse_polynomial_evaluator_unit #(
    parameter int MAX_TERMS    = spe_pkg::MAX_TERMS_DEF,
    parameter int MAX_EXPONENT = spe_pkg::MAX_EXPONENT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [spe_pkg::REQ_W-1:0]         req_type,
    input  logic signed [spe_pkg::COEF_W-1:0] coefficient,
    input  logic [spe_pkg::EXP_W-1:0]         exponent,
    input  logic signed [spe_pkg::X_W-1:0]    x_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [spe_pkg::VAL_W-1:0]  result_value,
    output logic                              overflow,
    output logic                              rejected,
    output logic [spe_pkg::CNT_OUT_W-1:0]     term_count
);

    spe_pkg::cmd_t  cmd;
    spe_pkg::stat_t st;

    spe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    spe_dp #(
        .MAX_TERMS    (MAX_TERMS),
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .req_type     (req_type),
        .coefficient  (coefficient),
        .exponent     (exponent),
        .x_value      (x_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .overflow     (overflow),
        .rejected     (rejected),
        .term_count   (term_count)
    );

endmodule
